/* design/skt_pkg.sv */
// Package for the sorted key table: request codes, status codes and the request record.
// Shared by skt_front, skt_queue, skt_back and sorted_key_table_unit.
package skt_pkg;

  localparam int KEY_W        = 32;
  localparam int ACT_W        = 2;
  localparam int STAT_W       = 2;
  localparam int POS_W        = 5;
  localparam int CAPACITY_DEF = 16;
  localparam int QUEUE_DEPTH  = 2;

  localparam logic [ACT_W-1:0] ACT_SEARCH = 2'd0;
  localparam logic [ACT_W-1:0] ACT_INSERT = 2'd1;
  localparam logic [ACT_W-1:0] ACT_DELETE = 2'd2;
  localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_MISS = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

  typedef enum logic [1:0] {
    OP_SEARCH,
    OP_INSERT,
    OP_DELETE,
    OP_CLEAR
  } op_t;

  typedef struct packed {
    op_t               op;
    logic signed [KEY_W-1:0] key;
  } req_t;

endpackage

/* design/skt_front.sv */
// Front end of the sorted key table: takes requests, decodes the action, holds one request.
// Depends on skt_pkg; feeds skt_queue.
module skt_front (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  input  logic [skt_pkg::ACT_W-1:0]             action,
  input  logic signed [skt_pkg::KEY_W-1:0]      key,
  output logic                                  busy,
  input  logic                                  q_full,
  output logic                                  push,
  output skt_pkg::req_t                         push_req
);

  logic          held;
  skt_pkg::req_t req;
  skt_pkg::op_t  op_dec;
  logic          take;

  always_comb begin
    unique case (action)
      skt_pkg::ACT_SEARCH: op_dec = skt_pkg::OP_SEARCH;
      skt_pkg::ACT_INSERT: op_dec = skt_pkg::OP_INSERT;
      skt_pkg::ACT_DELETE: op_dec = skt_pkg::OP_DELETE;
      default:             op_dec = skt_pkg::OP_CLEAR;
    endcase
  end

  assign busy     = held && q_full;
  assign take     = start && !busy;
  assign push     = held && !q_full;
  assign push_req = req;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (take) begin
      held <= 1'b1;
    end else if (push) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      req.op  <= op_dec;
      req.key <= key;
    end
  end

endmodule

/* design/skt_queue.sv */
// Short request queue between the front end and the table back end.
// Depends on skt_pkg for the request record.
module skt_queue #(
  parameter int DEPTH = skt_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  skt_pkg::req_t push_req,
  output logic          full,
  input  logic          pop,
  output logic          valid,
  output skt_pkg::req_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  skt_pkg::req_t  slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;
  logic             do_push;
  logic             do_pop;

  assign full    = (fill == CNT_W'(DEPTH));
  assign valid   = (fill != '0);
  assign head    = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_req;
    end
  end

endmodule

/* design/skt_back.sv */
// Back end of the sorted key table: a row of compare-and-shift cells, the count and results.
// Depends on skt_pkg; takes requests from skt_queue.
module skt_back #(
  parameter int CAPACITY = skt_pkg::CAPACITY_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              q_valid,
  input  skt_pkg::req_t                     q_head,
  output logic                              pop,
  output logic                              done,
  output logic [skt_pkg::STAT_W-1:0]        status,
  output logic [skt_pkg::POS_W-1:0]         position,
  output logic [skt_pkg::POS_W-1:0]         entry_count
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int KW    = skt_pkg::KEY_W;

  typedef enum logic {
    S_LOAD,
    S_EXEC
  } state_t;

  state_t                   state;
  skt_pkg::req_t            cur;
  logic signed [KW-1:0]     store      [CAPACITY];
  logic signed [KW-1:0]     store_next [CAPACITY];
  logic signed [KW-1:0]     up_src     [CAPACITY];
  logic signed [KW-1:0]     dn_src     [CAPACITY];
  logic [CNT_W-1:0]         cnt;
  logic [CNT_W-1:0]         cnt_next;
  logic [CAPACITY-1:0]      lt_now;
  logic [CAPACITY-1:0]      eq_now;
  logic [CAPACITY-1:0]      lt;
  logic                     hit;
  logic [CAPACITY:0]        edge_vec;
  logic [CNT_W-1:0]         rank;
  logic [CNT_W+4:0]         rank_ext;
  logic [CNT_W+4:0]         cnt_ext;
  logic [skt_pkg::STAT_W-1:0] stat_next;
  logic                     do_ins;
  logic                     do_del;
  logic                     is_full;

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      lt_now[i] = (CNT_W'(i) < cnt) && (store[i] < q_head.key);
      eq_now[i] = (CNT_W'(i) < cnt) && (store[i] == q_head.key);
    end
  end

  always_comb begin
    edge_vec[0] = !lt[0];
    for (int i = 1; i < CAPACITY; i++) begin
      edge_vec[i] = lt[i-1] && !lt[i];
    end
    edge_vec[CAPACITY] = lt[CAPACITY-1];
    rank = '0;
    for (int i = 0; i <= CAPACITY; i++) begin
      rank = rank | (edge_vec[i] ? CNT_W'(i) : '0);
    end
  end

  assign is_full = (cnt == CNT_W'(CAPACITY));
  assign do_ins  = (cur.op == skt_pkg::OP_INSERT) && !hit && !is_full;
  assign do_del  = (cur.op == skt_pkg::OP_DELETE) && hit;

  always_comb begin
    for (int i = 0; i < CAPACITY - 1; i++) begin
      up_src[i] = store[i+1];
    end
    up_src[CAPACITY-1] = store[CAPACITY-1];
    dn_src[0] = cur.key;
    for (int i = 1; i < CAPACITY; i++) begin
      dn_src[i] = store[i-1];
    end
    for (int i = 0; i < CAPACITY; i++) begin
      if (lt[i]) begin
        store_next[i] = store[i];
      end else if (do_ins) begin
        store_next[i] = edge_vec[i] ? cur.key : dn_src[i];
      end else if (do_del) begin
        store_next[i] = up_src[i];
      end else begin
        store_next[i] = store[i];
      end
    end
  end

  always_comb begin
    cnt_next  = cnt;
    stat_next = skt_pkg::ST_OK;
    unique case (cur.op)
      skt_pkg::OP_SEARCH: begin
        stat_next = hit ? skt_pkg::ST_OK : skt_pkg::ST_MISS;
      end
      skt_pkg::OP_INSERT: begin
        priority if (hit) begin
          stat_next = skt_pkg::ST_MISS;
        end else if (is_full) begin
          stat_next = skt_pkg::ST_FULL;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      skt_pkg::OP_DELETE: begin
        if (hit) begin
          cnt_next = cnt - 1'b1;
        end else begin
          stat_next = skt_pkg::ST_MISS;
        end
      end
      default: begin
        cnt_next = '0;
      end
    endcase
  end

  assign rank_ext = {5'b0, (cur.op == skt_pkg::OP_CLEAR) ? {CNT_W{1'b0}} : rank};
  assign cnt_ext  = {5'b0, cnt_next};
  assign pop      = (state == S_LOAD) && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      done <= (state == S_EXEC);
      unique case (state)
        S_LOAD: begin
          if (q_valid) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          cnt         <= cnt_next;
          status      <= stat_next;
          position    <= rank_ext[skt_pkg::POS_W-1:0];
          entry_count <= cnt_ext[skt_pkg::POS_W-1:0];
          state       <= S_LOAD;
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_head;
      lt  <= lt_now;
      hit <= |eq_now;
    end
    if (state == S_EXEC) begin
      for (int i = 0; i < CAPACITY; i++) begin
        store[i] <= store_next[i];
      end
    end
  end

  a_done_after_exec: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_EXEC))
    else $error("result strobe without an execute cycle");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_single_edge: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC) |-> $onehot(edge_vec))
    else $error("compare vector is not ordered");

  a_full_only_at_cap: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC && stat_next == skt_pkg::ST_FULL) |=> (cnt == CNT_W'(CAPACITY)))
    else $error("full reported below capacity");

  a_pop_in_load: assert property (@(posedge clk) disable iff (rst)
    pop |=> (state == S_EXEC))
    else $error("request popped but not executed");

endmodule

/* design/sorted_key_table_unit.sv */
// Sorted key table: up to CAPACITY distinct signed keys kept in ascending order.
// A request passes the front register, the queue, then the load and execute states.
// The cell row takes a new request only after the last: compare in load, shift in execute.
// A front register and a 2-entry queue take up to 3 requests ahead of the cell row.
// Reset (rst, synchronous) empties the table and the queue; the receiver cannot stall.
// Depends on skt_pkg, skt_front, skt_queue and skt_back.
module sorted_key_table_unit #(
  parameter int CAPACITY = skt_pkg::CAPACITY_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [skt_pkg::ACT_W-1:0]         action,
  input  logic signed [skt_pkg::KEY_W-1:0]  key,
  output logic                              busy,
  output logic                              done,
  output logic [skt_pkg::STAT_W-1:0]        status,
  output logic [skt_pkg::POS_W-1:0]         position,
  output logic [skt_pkg::POS_W-1:0]         entry_count
);

  logic          q_full;
  logic          push;
  skt_pkg::req_t push_req;
  logic          pop;
  logic          q_valid;
  skt_pkg::req_t q_head;

  skt_front u_front (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .action   (action),
    .key      (key),
    .busy     (busy),
    .q_full   (q_full),
    .push     (push),
    .push_req (push_req)
  );

  skt_queue #(
    .DEPTH (skt_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_req (push_req),
    .full     (q_full),
    .pop      (pop),
    .valid    (q_valid),
    .head     (q_head)
  );

  skt_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_head      (q_head),
    .pop         (pop),
    .done        (done),
    .status      (status),
    .position    (position),
    .entry_count (entry_count)
  );

endmodule

/* dv/sorted_key_table_unit_tb.sv */
// Testbench for sorted_key_table_unit: directed and random search, insert, delete and clear
// requests, checked against a sorted key table kept in the bench.
// Depends on skt_pkg and the sorted_key_table_unit RTL.
module sorted_key_table_unit_tb;

  localparam int TABLE_CAP = skt_pkg::CAPACITY_DEF;
  localparam int RANDOM_REQS = 600;
  localparam logic signed [skt_pkg::KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [skt_pkg::KEY_W-1:0] KEY_MAX = 32'sh7fff_ffff;

  typedef struct {
    logic [skt_pkg::STAT_W-1:0] status;
    logic [skt_pkg::POS_W-1:0]  position;
    logic [skt_pkg::POS_W-1:0]  entry_count;
  } table_result_t;

  logic clk = 1'b0;
  logic rst;
  logic start;
  logic [skt_pkg::ACT_W-1:0] action;
  logic signed [skt_pkg::KEY_W-1:0] key;
  logic busy;
  logic done;
  logic [skt_pkg::STAT_W-1:0] status;
  logic [skt_pkg::POS_W-1:0] position;
  logic [skt_pkg::POS_W-1:0] entry_count;

  logic signed [skt_pkg::KEY_W-1:0] held_keys[$];
  table_result_t pending_results[$];
  int error_count = 0;
  int random_sent = 0;
  bit steady = 1'b0;

  sorted_key_table_unit dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .action(action),
    .key(key),
    .busy(busy),
    .done(done),
    .status(status),
    .position(position),
    .entry_count(entry_count)
  );

  always #2 clk = ~clk;

  // Sorted table update: rank is the number of held keys below k.
  function automatic table_result_t apply_request(skt_pkg::op_t op,
                                                  logic signed [skt_pkg::KEY_W-1:0] k);
    table_result_t r;
    int rank;
    bit hit;
    r.status = skt_pkg::ST_OK;
    r.position = '0;
    if (op == skt_pkg::OP_CLEAR) begin
      held_keys.delete();
    end else begin
      rank = 0;
      while (rank < held_keys.size() && held_keys[rank] < k) rank++;
      hit = (rank < held_keys.size()) && (held_keys[rank] == k);
      r.position = skt_pkg::POS_W'(rank);
      case (op)
        skt_pkg::OP_SEARCH: begin
          if (!hit) r.status = skt_pkg::ST_MISS;
        end
        skt_pkg::OP_INSERT: begin
          if (hit) r.status = skt_pkg::ST_MISS;
          else if (held_keys.size() >= TABLE_CAP) r.status = skt_pkg::ST_FULL;
          else held_keys.insert(rank, k);
        end
        default: begin
          if (!hit) r.status = skt_pkg::ST_MISS;
          else held_keys.delete(rank);
        end
      endcase
    end
    r.entry_count = skt_pkg::POS_W'(held_keys.size());
    return r;
  endfunction

  task automatic issue_request(input skt_pkg::op_t op,
                               input logic signed [skt_pkg::KEY_W-1:0] k);
    start <= 1'b1;
    action <= op;
    key <= k;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(apply_request(op, k));
  endtask

  task automatic maybe_pause();
    if (!steady && $urandom_range(99) < 24) begin
      start <= 1'b0;
      action <= skt_pkg::ACT_W'($urandom);
      key <= $urandom;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    table_result_t exp_r;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $error("result strobe with no request pending");
        error_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (status !== exp_r.status) begin
          $error("status: expected %0d, got %0d", exp_r.status, status);
          error_count++;
        end
        if (position !== exp_r.position) begin
          $error("position: expected %0d, got %0d", exp_r.position, position);
          error_count++;
        end
        if (entry_count !== exp_r.entry_count) begin
          $error("entry_count: expected %0d, got %0d", exp_r.entry_count, entry_count);
          error_count++;
        end
      end
    end
  end

  // Search and delete on an empty table both miss at rank 0.
  task automatic test_empty_table();
    issue_request(skt_pkg::OP_SEARCH, 32'sd0);
    maybe_pause();
    issue_request(skt_pkg::OP_DELETE, KEY_MAX);
    maybe_pause();
  endtask

  task automatic test_extreme_keys();
    issue_request(skt_pkg::OP_INSERT, KEY_MAX);
    maybe_pause();
    issue_request(skt_pkg::OP_INSERT, KEY_MIN);
    maybe_pause();
    issue_request(skt_pkg::OP_INSERT, KEY_MAX);
    maybe_pause();
    issue_request(skt_pkg::OP_SEARCH, KEY_MIN);
    maybe_pause();
    issue_request(skt_pkg::OP_SEARCH, -32'sd1);
    maybe_pause();
    issue_request(skt_pkg::OP_DELETE, 32'sd0);
    maybe_pause();
    issue_request(skt_pkg::OP_DELETE, KEY_MIN);
    maybe_pause();
  endtask

  // Fill to capacity, then a new key reports full, a held key reports miss, and clear empties.
  task automatic test_full_table();
    int i;
    for (i = 0; held_keys.size() < TABLE_CAP; i++) begin
      issue_request(skt_pkg::OP_INSERT, (i % 2) ? -(i * 1000) : (i * 977 + 3));
      maybe_pause();
    end
    issue_request(skt_pkg::OP_INSERT, 32'sd12345);
    maybe_pause();
    issue_request(skt_pkg::OP_INSERT, KEY_MAX);
    maybe_pause();
    issue_request(skt_pkg::OP_CLEAR, $urandom);
    maybe_pause();
  endtask

  task automatic test_sender_hold_off();
    issue_request(skt_pkg::OP_INSERT, -32'sd7);
    wait_drained();
    issue_request(skt_pkg::OP_SEARCH, -32'sd7);
    maybe_pause();
  endtask

  // Episodes over a small key pool so that hits, duplicates and a full table are common.
  task automatic test_random_mix();
    logic signed [skt_pkg::KEY_W-1:0] key_pool[24];
    logic signed [skt_pkg::KEY_W-1:0] k;
    int pool_n, mode, len, i, roll;
    skt_pkg::op_t op;
    while (random_sent < RANDOM_REQS) begin
      pool_n = $urandom_range(4, 24);
      for (i = 0; i < pool_n; i++) begin
        roll = $urandom_range(99);
        if (roll < 10) key_pool[i] = KEY_MIN;
        else if (roll < 20) key_pool[i] = KEY_MAX;
        else if (roll < 50) key_pool[i] = $signed($urandom_range(40)) - 20;
        else key_pool[i] = $urandom;
      end
      mode = $urandom_range(2);
      len = $urandom_range(20, 50);
      for (i = 0; i < len && random_sent < RANDOM_REQS; i++) begin
        steady = (random_sent >= 250 && random_sent < 400);
        roll = $urandom_range(99);
        case (mode)
          0: op = (roll < 60) ? skt_pkg::OP_INSERT :
                  (roll < 80) ? skt_pkg::OP_SEARCH :
                  (roll < 98) ? skt_pkg::OP_DELETE : skt_pkg::OP_CLEAR;
          1: op = (roll < 20) ? skt_pkg::OP_INSERT :
                  (roll < 43) ? skt_pkg::OP_SEARCH :
                  (roll < 98) ? skt_pkg::OP_DELETE : skt_pkg::OP_CLEAR;
          default: op = (roll < 33) ? skt_pkg::OP_INSERT :
                        (roll < 66) ? skt_pkg::OP_SEARCH :
                        (roll < 98) ? skt_pkg::OP_DELETE : skt_pkg::OP_CLEAR;
        endcase
        if ($urandom_range(99) < 15) k = $urandom;
        else k = key_pool[$urandom_range(pool_n - 1)];
        issue_request(op, k);
        random_sent++;
        maybe_pause();
      end
      if ($urandom_range(3) == 0) wait_drained();
    end
    steady = 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    action = skt_pkg::ACT_SEARCH;
    key = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_empty_table();
    test_extreme_keys();
    test_full_table();
    test_sender_hold_off();
    test_random_mix();
    wait_drained();
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("[sorted_key_table_unit] OK");
    end else begin
      $display("[sorted_key_table_unit] ERROR");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("[sorted_key_table_unit] ERROR");
    $finish;
  end

endmodule

/* sorted_key_table_unit.f */
design/skt_pkg.sv
design/skt_front.sv
design/skt_queue.sv
design/skt_back.sv
design/sorted_key_table_unit.sv
dv/sorted_key_table_unit_tb.sv
